// ===== rtl/core/owbm_pkg.sv =====
// owbm_pkg: shared types and constants for the one-wire bus master
// phase encoding, request and error codes, register indexes and reset values
// no dependencies
package owbm_pkg;

  localparam int unsigned CFG_WIDTH = 12;
  localparam int unsigned CFG_COUNT = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // default timing constants in ticks, and the default tick counter width
  localparam int unsigned DEF_PRESENCE_HIGH_MIN = 15;
  localparam int unsigned DEF_PRESENCE_LOW_MIN  = 60;
  localparam int unsigned DEF_PRESENCE_LOW_MAX  = 240;
  localparam int unsigned DEF_SLOT_MAX          = 120;
  localparam int unsigned DEF_RECOVERY_TICKS    = 1;
  localparam int unsigned DEF_COUNT_WIDTH       = 12;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_RESET = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_BUS_LOW   = 2'd1,
    ERR_PRESENCE  = 2'd2,
    ERR_SLOT_TOUT = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_PLOW,
    PH_RST_TAIL,
    PH_WR_LOW,
    PH_WR_REC,
    PH_RD_LOW,
    PH_RD_SAMPLE,
    PH_RD_HIGH,
    PH_RD_REC
  } phase_t;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_WIDTH-1:0] cfg_word_t;

  localparam cfg_idx_t CFG_RESET_LOW     = 3'd0;
  localparam cfg_idx_t CFG_RESET_HIGH    = 3'd1;
  localparam cfg_idx_t CFG_PRES_WAIT_MAX = 3'd2;
  localparam cfg_idx_t CFG_WR_ONE_LOW    = 3'd3;
  localparam cfg_idx_t CFG_WR_ZERO_LOW   = 3'd4;
  localparam cfg_idx_t CFG_RD_INIT       = 3'd5;
  localparam cfg_idx_t CFG_RD_SAMPLE     = 3'd6;
  localparam cfg_idx_t CFG_SLOT_MIN      = 3'd7;

  localparam cfg_word_t CFG_RESET_VAL [CFG_COUNT] = '{
    12'd480, 12'd480, 12'd60, 12'd6, 12'd60, 12'd6, 12'd15, 12'd70
  };

endpackage

// ===== rtl/core/one_wire_bus_master.sv =====
// one_wire_bus_master: tick-driven timing engine for a single-wire bus master
// the result beat for a taken tick is registered and appears from the output register in the next cycle
// throughput: one tick per cycle; in_stall is raised only while a held result is stalled
// all timing state updates in one pass of logic between the state and output registers
// reset (rst_n low, synchronous): phase idle, counters cleared, configuration registers at defaults
// depends on owbm_pkg
module one_wire_bus_master #(
  parameter int unsigned PRESENCE_HIGH_MIN = owbm_pkg::DEF_PRESENCE_HIGH_MIN,
  parameter int unsigned PRESENCE_LOW_MIN  = owbm_pkg::DEF_PRESENCE_LOW_MIN,
  parameter int unsigned PRESENCE_LOW_MAX  = owbm_pkg::DEF_PRESENCE_LOW_MAX,
  parameter int unsigned SLOT_MAX          = owbm_pkg::DEF_SLOT_MAX,
  parameter int unsigned RECOVERY_TICKS    = owbm_pkg::DEF_RECOVERY_TICKS,
  parameter int unsigned COUNT_WIDTH       = owbm_pkg::DEF_COUNT_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  owbm_pkg::cfg_idx_t        cfg_index,
  input  owbm_pkg::cfg_word_t       cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_req_type,
  input  logic                      in_write_value,
  input  logic                      in_bus_level,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_drive_low,
  output logic                      out_busy_res,
  output logic                      out_done_res,
  output logic                      out_result_bit,
  output logic [1:0]                out_error_code
);
  import owbm_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned XW = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  cfg_word_t     cfg_r [CFG_COUNT];
  phase_t        phase_r, phase_nxt;
  logic [CW-1:0] tick_r, tick_nxt;
  logic [CW-1:0] mark_r, mark_nxt;
  logic          pres_r, pres_nxt;
  logic          samp_r, samp_nxt;
  logic [1:0]    perr_r, perr_nxt;
  logic          wlat_r, wlat_nxt;

  logic          drive_nxt, done_nxt, res_nxt;
  logic [1:0]    err_nxt;

  logic          out_valid_r, drive_r, busy_r, done_r, res_r;
  logic [1:0]    err_r;
  logic          accept;

  function automatic logic reached(input logic [CW-1:0] c, input logic [XW-1:0] t);
    return (XW'(c) >= t) || (c == CNT_MAX);
  endfunction

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_COUNT; i++) begin
        cfg_r[i] <= CFG_RESET_VAL[i];
      end
    end else if (cfg_wr_en) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  // next state for one tick, in the order the steps take effect
  always_comb begin
    logic [CW-1:0] diff;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    mark_nxt  = mark_r;
    pres_nxt  = pres_r;
    samp_nxt  = samp_r;
    perr_nxt  = perr_r;
    wlat_nxt  = wlat_r;
    drive_nxt = 1'b0;
    done_nxt  = 1'b0;
    res_nxt   = 1'b0;
    err_nxt   = ERR_OK;
    diff      = '0;

    if (phase_nxt == PH_IDLE && in_req_type != REQ_NONE) begin
      tick_nxt = '0;
      mark_nxt = '0;
      pres_nxt = 1'b0;
      samp_nxt = 1'b0;
      perr_nxt = ERR_OK;
      unique case (in_req_type)
        REQ_RESET: phase_nxt = PH_RST_LOW;
        REQ_WRITE: begin
          wlat_nxt  = in_write_value;
          phase_nxt = PH_WR_LOW;
        end
        default:   phase_nxt = PH_RD_LOW;
      endcase
    end

    if (phase_nxt != PH_IDLE && tick_nxt != CNT_MAX) begin
      tick_nxt = tick_nxt + CW'(1);
    end

    unique case (phase_nxt)
      PH_RST_LOW: begin
        drive_nxt = 1'b1;
        if (reached(tick_nxt, XW'(cfg_r[CFG_RESET_LOW]))) begin
          phase_nxt = PH_RST_WAIT;
          tick_nxt  = '0;
        end
      end
      PH_RST_WAIT: begin
        if (!in_bus_level) begin
          if (tick_nxt <= CW'(1)) begin
            perr_nxt  = ERR_BUS_LOW;
            phase_nxt = PH_RST_TAIL;
          end else begin
            if (XW'(tick_nxt) < XW'(PRESENCE_HIGH_MIN)) begin
              perr_nxt = ERR_PRESENCE;
            end
            pres_nxt  = 1'b1;
            mark_nxt  = tick_nxt;
            phase_nxt = PH_RST_PLOW;
          end
        end else if (reached(tick_nxt, XW'(cfg_r[CFG_PRES_WAIT_MAX]))) begin
          phase_nxt = PH_RST_TAIL;
        end
      end
      PH_RST_PLOW: begin
        diff = tick_nxt - mark_nxt;
        if (in_bus_level) begin
          if (XW'(diff) < XW'(PRESENCE_LOW_MIN) && perr_nxt == ERR_OK) begin
            perr_nxt = ERR_PRESENCE;
          end
          phase_nxt = PH_RST_TAIL;
        end else if (tick_nxt == CNT_MAX || XW'(diff) >= XW'(PRESENCE_LOW_MAX)) begin
          phase_nxt = PH_RST_TAIL;
        end
      end
      PH_WR_LOW: begin
        drive_nxt = 1'b1;
        if (reached(tick_nxt, XW'(wlat_nxt ? cfg_r[CFG_WR_ONE_LOW]
                                           : cfg_r[CFG_WR_ZERO_LOW]))) begin
          mark_nxt  = tick_nxt;
          phase_nxt = PH_WR_REC;
        end
      end
      PH_RD_LOW: begin
        drive_nxt = 1'b1;
        if (reached(tick_nxt, XW'(cfg_r[CFG_RD_INIT]))) begin
          phase_nxt = PH_RD_SAMPLE;
        end
      end
      PH_RD_SAMPLE: begin
        if (reached(tick_nxt, XW'(cfg_r[CFG_RD_SAMPLE]))) begin
          samp_nxt = in_bus_level;
          if (in_bus_level) begin
            mark_nxt  = tick_nxt;
            phase_nxt = PH_RD_REC;
          end else begin
            phase_nxt = PH_RD_HIGH;
          end
        end
      end
      PH_RD_HIGH: begin
        if (reached(tick_nxt, XW'(SLOT_MAX))) begin
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
          res_nxt   = 1'b0;
          err_nxt   = ERR_SLOT_TOUT;
        end else if (in_bus_level) begin
          mark_nxt  = tick_nxt;
          phase_nxt = PH_RD_REC;
        end
      end
      default: begin
      end
    endcase

    // completion checks see any phase change made above
    if (phase_nxt == PH_RST_TAIL && reached(tick_nxt, XW'(cfg_r[CFG_RESET_HIGH]))) begin
      phase_nxt = PH_IDLE;
      done_nxt  = 1'b1;
      res_nxt   = pres_nxt;
      err_nxt   = perr_nxt;
    end else if (phase_nxt == PH_WR_REC || phase_nxt == PH_RD_REC) begin
      diff = tick_nxt - mark_nxt;
      if ((tick_nxt == CNT_MAX || XW'(diff) >= XW'(RECOVERY_TICKS))
          && reached(tick_nxt, XW'(cfg_r[CFG_SLOT_MIN]))) begin
        res_nxt   = (phase_nxt == PH_RD_REC) ? samp_nxt : 1'b0;
        phase_nxt = PH_IDLE;
        done_nxt  = 1'b1;
        err_nxt   = ERR_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      mark_r  <= '0;
      pres_r  <= 1'b0;
      samp_r  <= 1'b0;
      perr_r  <= ERR_OK;
      wlat_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      mark_r  <= mark_nxt;
      pres_r  <= pres_nxt;
      samp_r  <= samp_nxt;
      perr_r  <= perr_nxt;
      wlat_r  <= wlat_nxt;
    end
  end

  // output register: holds a beat while the far side stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drive_r <= drive_nxt;
      busy_r  <= (phase_nxt != PH_IDLE);
      done_r  <= done_nxt;
      res_r   <= res_nxt;
      err_r   <= err_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drive_low  = drive_r;
  assign out_busy_res   = busy_r;
  assign out_done_res   = done_r;
  assign out_result_bit = res_r;
  assign out_error_code = err_r;

endmodule

// ===== rtl/core/owbm_checker.sv =====
// owbm_checker: port-level checks for the one-wire bus master
// bound to one_wire_bus_master; depends on owbm_pkg
module owbm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_drive_low,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic       out_result_bit,
  input logic [1:0] out_error_code
);
  import owbm_pkg::*;

  // input side only backs up behind a stalled result beat
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result beat");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> !out_busy_res)
    else $error("done beat still shows busy");

  a_quiet_when_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |-> (!out_result_bit && out_error_code == ERR_OK))
    else $error("result or error without done");

  a_timeout_no_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res && out_error_code == ERR_SLOT_TOUT)
      |-> (!out_result_bit && !out_drive_low))
    else $error("slot timeout with result bit or drive");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_drive_low)
      && $stable(out_busy_res) && $stable(out_done_res)
      && $stable(out_result_bit) && $stable(out_error_code)))
    else $error("stalled result beat changed");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_drive_low  (out_drive_low),
  .out_busy_res   (out_busy_res),
  .out_done_res   (out_done_res),
  .out_result_bit (out_result_bit),
  .out_error_code (out_error_code)
);
